### rtl/core/dprt_pkg.sv
// ----------------------------------------------------------------------------
// dprt_pkg
// Types and constants shared by the dual path route table.
// ----------------------------------------------------------------------------
`default_nettype none
package dprt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam logic [1:0] REQ_ADV    = 2'd0;
  localparam logic [1:0] REQ_PACKET = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] KIND_LOCAL = 2'd0;
  localparam logic [1:0] KIND_FWD   = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;
  localparam logic [1:0] KIND_ADV   = 2'd3;

  localparam logic CFG_OWN   = 1'b0;
  localparam logic CFG_BCAST = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] dest_addr;
    logic [7:0] via_addr;
    logic [7:0] advertised_metric;
  } in_word_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_hop;
    logic [7:0] out_dest;
    logic [7:0] out_metric;
    logic       out_last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE,
    ST_ADV_SELF,
    ST_ADV_SCAN,
    ST_SWEEP
  } state_t;

endpackage
`default_nettype wire

### rtl/core/dual_path_route_table_unit.sv
// ----------------------------------------------------------------------------
// dual_path_route_table_unit
// Distance-vector route table, primary and backup path per destination.
// ----------------------------------------------------------------------------
// channel  ports                         handshake
// in       in_word                       start & !busy
// out      out_word                      out_valid, one cycle, no stall
// cfg      cfg_index, cfg_data           cfg_valid & cfg_ready
//
// a packet scans the table one entry per cycle with one compare unit until it
// matches or reaches the last entry; a local destination ends it at the first entry
// an advertisement scans the same way and then merges in the ST_MERGE state
// advertise ticks emit the self route and then one word per valid entry while
// scanning the table; stale and purge ticks sweep the whole table
// reset clears valid and stale bits at once; busy stays high during a run
// results are dropped nowhere since the receiver cannot stall
`default_nettype none
module dual_path_route_table_unit #(
  parameter int unsigned TABLE_ENTRIES = dprt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire dprt_pkg::in_word_t in_word,
  output logic                    out_valid,
  output dprt_pkg::out_word_t     out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  dprt_pkg::state_t state_r, state_nxt;
  dprt_pkg::in_word_t req_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0] phase_r;
  logic [7:0] own_r, bcast_r;
  logic found_r, free_found_r;
  logic [IW-1:0] hit_r, free_r;

  logic [TABLE_ENTRIES-1:0] ev_r, ps_r, bv_r, bs_r;
  logic [7:0] dst_r [TABLE_ENTRIES];
  logic [7:0] ph_r  [TABLE_ENTRIES];
  logic [7:0] pm_r  [TABLE_ENTRIES];
  logic [7:0] bh_r  [TABLE_ENTRIES];
  logic [7:0] bm_r  [TABLE_ENTRIES];

  logic [IW-1:0] ix;
  logic scan_done, match, more_valid;
  logic pkt_local;
  logic [7:0] m;
  logic accept;

  assign ix        = idx_r[IW-1:0];
  assign scan_done = (idx_r == CW'(TABLE_ENTRIES - 1));
  assign match     = ev_r[ix] && (dst_r[ix] == req_r.dest_addr);
  assign pkt_local = (req_r.req_type == dprt_pkg::REQ_PACKET) &&
                     (req_r.dest_addr == own_r || req_r.dest_addr == bcast_r);
  assign m         = (req_r.advertised_metric == 8'hff) ? 8'hff :
                     req_r.advertised_metric + 8'd1;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    more_valid = 1'b0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (k > int'(ix) && ev_r[k]) more_valid = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      dprt_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          case (in_word.req_type)
            dprt_pkg::REQ_ADV: begin
              if (in_word.dest_addr != own_r && in_word.via_addr != own_r)
                state_nxt = dprt_pkg::ST_SCAN;
            end
            dprt_pkg::REQ_PACKET: state_nxt = dprt_pkg::ST_SCAN;
            dprt_pkg::REQ_TICK: begin
              if (phase_r[0]) state_nxt = dprt_pkg::ST_SWEEP;
              else state_nxt = dprt_pkg::ST_ADV_SELF;
            end
            default: state_nxt = dprt_pkg::ST_IDLE;
          endcase
        end
      end
      dprt_pkg::ST_SCAN: begin
        idx_nxt = idx_r + CW'(1);
        if (scan_done || match || pkt_local) begin
          if (req_r.req_type == dprt_pkg::REQ_ADV) state_nxt = dprt_pkg::ST_MERGE;
          else state_nxt = dprt_pkg::ST_IDLE;
        end
      end
      dprt_pkg::ST_MERGE:    state_nxt = dprt_pkg::ST_IDLE;
      dprt_pkg::ST_ADV_SELF: state_nxt = (|ev_r) ? dprt_pkg::ST_ADV_SCAN : dprt_pkg::ST_IDLE;
      dprt_pkg::ST_ADV_SCAN, dprt_pkg::ST_SWEEP: begin
        idx_nxt = idx_r + CW'(1);
        if (scan_done) state_nxt = dprt_pkg::ST_IDLE;
      end
      default: state_nxt = dprt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != dprt_pkg::ST_IDLE);
    out_valid = 1'b0;
    out_word  = '0;
    case (state_r)
      dprt_pkg::ST_SCAN: begin
        if (req_r.req_type == dprt_pkg::REQ_PACKET) begin
          out_word.out_dest = req_r.dest_addr;
          out_word.out_last = 1'b1;
          if (pkt_local) begin
            out_valid = 1'b1;
            out_word.out_kind = dprt_pkg::KIND_LOCAL;
          end else if (match) begin
            out_valid = 1'b1;
            out_word.out_kind = dprt_pkg::KIND_FWD;
            out_word.out_hop  = ph_r[ix];
          end else if (scan_done) begin
            out_valid = 1'b1;
            out_word.out_kind = dprt_pkg::KIND_DROP;
          end
        end
      end
      dprt_pkg::ST_ADV_SELF: begin
        out_valid = 1'b1;
        out_word.out_kind = dprt_pkg::KIND_ADV;
        out_word.out_hop  = own_r;
        out_word.out_dest = own_r;
        out_word.out_last = ~(|ev_r);
      end
      dprt_pkg::ST_ADV_SCAN: begin
        out_valid = ev_r[ix];
        out_word.out_kind   = dprt_pkg::KIND_ADV;
        out_word.out_hop    = own_r;
        out_word.out_dest   = dst_r[ix];
        out_word.out_metric = pm_r[ix];
        out_word.out_last   = ~more_valid;
      end
      default: out_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dprt_pkg::ST_IDLE;
      idx_r   <= '0;
      phase_r <= '0;
      own_r   <= 8'd0;
      bcast_r <= 8'hff;
      ev_r    <= '0;
      ps_r    <= '0;
      bv_r    <= '0;
      bs_r    <= '0;
      found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (cfg_valid) begin
        if (cfg_index == dprt_pkg::CFG_OWN) own_r <= cfg_data;
        else bcast_r <= cfg_data;
      end
      if (accept) begin
        req_r <= in_word;
        found_r <= 1'b0;
        free_found_r <= 1'b0;
        if (in_word.req_type == dprt_pkg::REQ_TICK) phase_r <= phase_r + 2'd1;
      end
      case (state_r)
        dprt_pkg::ST_SCAN: begin
          if (match) begin
            found_r <= 1'b1;
            hit_r   <= ix;
          end
          if (!ev_r[ix] && !free_found_r) begin
            free_found_r <= 1'b1;
            free_r       <= ix;
          end
        end
        dprt_pkg::ST_MERGE: begin
          if (found_r) begin
            if (pm_r[hit_r] > m) begin
              bh_r[hit_r] <= ph_r[hit_r];
              bm_r[hit_r] <= pm_r[hit_r];
              bs_r[hit_r] <= ps_r[hit_r];
              bv_r[hit_r] <= 1'b1;
              ph_r[hit_r] <= req_r.via_addr;
              pm_r[hit_r] <= m;
              ps_r[hit_r] <= 1'b0;
            end else begin
              if (ph_r[hit_r] == req_r.via_addr && pm_r[hit_r] == m)
                ps_r[hit_r] <= 1'b0;
              if (!bv_r[hit_r] || bm_r[hit_r] > m) begin
                bv_r[hit_r] <= 1'b1;
                bh_r[hit_r] <= req_r.via_addr;
                bm_r[hit_r] <= m;
                bs_r[hit_r] <= 1'b0;
              end else if (!(ph_r[hit_r] == req_r.via_addr && pm_r[hit_r] == m) &&
                           bh_r[hit_r] == req_r.via_addr && bm_r[hit_r] == m) begin
                bs_r[hit_r] <= 1'b0;
              end
            end
          end else if (free_found_r) begin
            ev_r[free_r]  <= 1'b1;
            dst_r[free_r] <= req_r.dest_addr;
            ph_r[free_r]  <= req_r.via_addr;
            pm_r[free_r]  <= m;
            ps_r[free_r]  <= 1'b0;
            bv_r[free_r]  <= 1'b0;
            bs_r[free_r]  <= 1'b0;
          end
        end
        dprt_pkg::ST_SWEEP: begin
          if (ev_r[ix]) begin
            if (phase_r == 2'd2) begin
              ps_r[ix] <= 1'b1;
              if (bv_r[ix]) bs_r[ix] <= 1'b1;
            end else if (ps_r[ix]) begin
              if (!bv_r[ix] || bs_r[ix]) begin
                ev_r[ix] <= 1'b0;
                bv_r[ix] <= 1'b0;
              end else begin
                ph_r[ix] <= bh_r[ix];
                pm_r[ix] <= bm_r[ix];
                ps_r[ix] <= bs_r[ix];
                bh_r[ix] <= ph_r[ix];
                bm_r[ix] <= pm_r[ix];
                bs_r[ix] <= ps_r[ix];
                bv_r[ix] <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.req_type == dprt_pkg::REQ_PACKET) |=> busy)
    else $error("packet not taken into a run");
  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a run");
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.out_last) |=> !out_valid)
    else $error("result after last");

endmodule
`default_nettype wire

### sim/tb_dual_path_route_table_unit.sv
// ----------------------------------------------------------------------------
// tb_dual_path_route_table_unit
// Self-checking bench for the route table: a directed list of advertisements,
// packets and ticks, then random traffic, with idle gaps in several phases.
// Each word is predicted by a route table model and checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_dual_path_route_table_unit;

  localparam int NENT = dprt_pkg::TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst_n, start, busy, out_valid, cfg_valid, cfg_ready, cfg_index;
  logic [7:0] cfg_data;
  dprt_pkg::in_word_t in_word;
  dprt_pkg::out_word_t out_word;

  dual_path_route_table_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // route table copy
  logic [7:0] own_addr, bcast_addr;
  logic       rt_valid [NENT];
  logic [7:0] rt_dest [NENT], rt_phop [NENT], rt_pmet [NENT];
  logic [7:0] rt_bhop [NENT], rt_bmet [NENT];
  logic       rt_pstale [NENT], rt_bvalid [NENT], rt_bstale [NENT];
  logic [1:0] tick_phase;

  dprt_pkg::in_word_t  pending_words [$];
  dprt_pkg::out_word_t expected_words [$];
  int        fail_count, mismatch_count, cycle_count;
  int        send_idle_pct;
  logic      send_hold;
  logic      busy_at_edge;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int find_route(logic [7:0] d);
    for (int i = 0; i < NENT; i++)
      if (rt_valid[i] && rt_dest[i] == d) return i;
    return -1;
  endfunction

  function automatic void swap_route(int i);
    logic [7:0] h, m;
    logic s;
    h = rt_phop[i]; m = rt_pmet[i]; s = rt_pstale[i];
    rt_phop[i] = rt_bhop[i]; rt_pmet[i] = rt_bmet[i]; rt_pstale[i] = rt_bstale[i];
    rt_bhop[i] = h; rt_bmet[i] = m; rt_bstale[i] = s;
  endfunction

  function automatic void push_word(logic [1:0] k, logic [7:0] h, logic [7:0] d,
                                    logic [7:0] m, logic l);
    dprt_pkg::out_word_t w;
    w.out_kind = k; w.out_hop = h; w.out_dest = d; w.out_metric = m; w.out_last = l;
    expected_words.push_back(w);
  endfunction

  function automatic void merge_route(logic [7:0] d, logic [7:0] via, logic [7:0] adv);
    logic [7:0] m;
    int i;
    m = (adv == 8'd255) ? 8'd255 : adv + 8'd1;
    if (d == own_addr || via == own_addr) return;
    i = find_route(d);
    if (i < 0) begin
      for (i = 0; i < NENT; i++)
        if (!rt_valid[i]) break;
      if (i >= NENT) return;
      rt_valid[i] = 1'b1; rt_dest[i] = d; rt_phop[i] = via; rt_pmet[i] = m;
      rt_pstale[i] = 1'b0; rt_bvalid[i] = 1'b0; rt_bstale[i] = 1'b0;
      return;
    end
    if (rt_pmet[i] > m) begin
      swap_route(i);
      rt_bvalid[i] = 1'b1;
      rt_phop[i] = via; rt_pmet[i] = m; rt_pstale[i] = 1'b0;
    end else if (!rt_bvalid[i] || rt_bmet[i] > m) begin
      rt_bvalid[i] = 1'b1; rt_bhop[i] = via; rt_bmet[i] = m; rt_bstale[i] = 1'b0;
    end
    if (rt_phop[i] == via && rt_pmet[i] == m) rt_pstale[i] = 1'b0;
    else if (rt_bvalid[i] && rt_bhop[i] == via && rt_bmet[i] == m) rt_bstale[i] = 1'b0;
  endfunction

  function automatic void predict_route(dprt_pkg::in_word_t w);
    int i, last;
    if (w.req_type == dprt_pkg::REQ_ADV) begin
      merge_route(w.dest_addr, w.via_addr, w.advertised_metric);
    end else if (w.req_type == dprt_pkg::REQ_PACKET) begin
      if (w.dest_addr == own_addr || w.dest_addr == bcast_addr) begin
        push_word(dprt_pkg::KIND_LOCAL, 8'd0, w.dest_addr, 8'd0, 1'b1);
      end else begin
        i = find_route(w.dest_addr);
        if (i >= 0) push_word(dprt_pkg::KIND_FWD, rt_phop[i], w.dest_addr, 8'd0, 1'b1);
        else push_word(dprt_pkg::KIND_DROP, 8'd0, w.dest_addr, 8'd0, 1'b1);
      end
    end else if (w.req_type == dprt_pkg::REQ_TICK) begin
      case (tick_phase)
        2'd0, 2'd2: begin
          last = -1;
          for (i = 0; i < NENT; i++)
            if (rt_valid[i]) last = i;
          push_word(dprt_pkg::KIND_ADV, own_addr, own_addr, 8'd0, last < 0);
          for (i = 0; i < NENT; i++)
            if (rt_valid[i])
              push_word(dprt_pkg::KIND_ADV, own_addr, rt_dest[i], rt_pmet[i],
                        i == last);
        end
        2'd1: begin
          for (i = 0; i < NENT; i++)
            if (rt_valid[i]) begin
              rt_pstale[i] = 1'b1;
              if (rt_bvalid[i]) rt_bstale[i] = 1'b1;
            end
        end
        default: begin
          for (i = 0; i < NENT; i++)
            if (rt_valid[i] && rt_pstale[i]) begin
              if (!rt_bvalid[i] || rt_bstale[i]) begin
                rt_valid[i] = 1'b0; rt_bvalid[i] = 1'b0;
              end else begin
                swap_route(i);
                rt_bvalid[i] = 1'b0;
              end
            end
        end
      endcase
      tick_phase = tick_phase + 2'd1;
    end
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy_at_edge) begin
      // previous word taken at the last rising edge
      start <= 1'b0;
      if (!send_hold && pending_words.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        in_word <= pending_words.pop_front();
      end
    end else if (!start && !send_hold && pending_words.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      start <= 1'b1;
      in_word <= pending_words.pop_front();
    end
  end

  // monitor
  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (start && !busy) predict_route(in_word);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dprt_pkg::CFG_OWN) own_addr = cfg_data;
        else bcast_addr = cfg_data;
      end
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (mismatch_count++ < 10) $display("unexpected word %h", out_word);
        end else if (expected_words[0] !== out_word) begin
          fail_count++;
          if (mismatch_count++ < 10)
            $display({"mismatch: exp kind %0d hop %0d dest %0d metric %0d last %0d,",
                      " got kind %0d hop %0d dest %0d metric %0d last %0d"},
                     expected_words[0].out_kind, expected_words[0].out_hop,
                     expected_words[0].out_dest, expected_words[0].out_metric,
                     expected_words[0].out_last, out_word.out_kind, out_word.out_hop,
                     out_word.out_dest, out_word.out_metric, out_word.out_last);
          void'(expected_words.pop_front());
        end else begin
          void'(expected_words.pop_front());
        end
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic add_word(logic [1:0] r, logic [7:0] d, logic [7:0] v, logic [7:0] m);
    dprt_pkg::in_word_t w;
    w.req_type = r; w.dest_addr = d; w.via_addr = v; w.advertised_metric = m;
    pending_words.push_back(w);
  endtask

  task automatic drain_all();
    while (pending_words.size() > 0 || start || busy || expected_words.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n, logic [7:0] own);
    logic [7:0] d;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      d = (own & 8'hf0) | 8'($urandom_range(19));
      if (r < 45)
        add_word(dprt_pkg::REQ_ADV, ($urandom_range(9) == 0) ? 8'($urandom) : d,
                 ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6)),
                 ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(12)));
      else if (r < 75)
        add_word(dprt_pkg::REQ_PACKET, ($urandom_range(7) == 0) ? 8'($urandom) : d,
                 8'($urandom), 8'($urandom));
      else if (r < 97)
        add_word(dprt_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
      else
        add_word(2'd3, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; in_word = '0;
    cfg_valid = 1'b0; cfg_index = dprt_pkg::CFG_OWN; cfg_data = 8'd0;
    own_addr = 8'd0; bcast_addr = 8'd255; tick_phase = 2'd0;
    fail_count = 0; mismatch_count = 0; cycle_count = 0;
    send_idle_pct = 0; send_hold = 1'b0;
    for (int i = 0; i < NENT; i++) begin
      rt_valid[i] = 1'b0; rt_pstale[i] = 1'b0; rt_bvalid[i] = 1'b0; rt_bstale[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, self entries, swaps, full table, packets, all tick phases
    add_word(dprt_pkg::REQ_TICK, 8'd0, 8'd0, 8'd0);
    add_word(dprt_pkg::REQ_ADV, 8'd10, 8'd1, 8'd255);
    add_word(dprt_pkg::REQ_ADV, 8'd10, 8'd2, 8'd3);
    add_word(dprt_pkg::REQ_ADV, 8'd10, 8'd3, 8'd5);
    add_word(dprt_pkg::REQ_ADV, 8'd10, 8'd2, 8'd3);
    add_word(dprt_pkg::REQ_ADV, 8'd0, 8'd4, 8'd1);
    add_word(dprt_pkg::REQ_ADV, 8'd20, 8'd0, 8'd1);
    add_word(dprt_pkg::REQ_ADV, 8'd255, 8'd255, 8'd0);
    add_word(dprt_pkg::REQ_PACKET, 8'd0, 8'hff, 8'hff);
    add_word(dprt_pkg::REQ_PACKET, 8'd255, 8'd0, 8'd0);
    add_word(dprt_pkg::REQ_PACKET, 8'd10, 8'd0, 8'd0);
    add_word(dprt_pkg::REQ_PACKET, 8'd77, 8'd0, 8'd0);
    add_word(dprt_pkg::REQ_TICK, 8'hff, 8'hff, 8'hff);
    add_word(dprt_pkg::REQ_TICK, 8'd0, 8'd0, 8'd0);
    add_word(dprt_pkg::REQ_ADV, 8'd10, 8'd3, 8'd5);
    add_word(dprt_pkg::REQ_TICK, 8'd0, 8'd0, 8'd0);
    add_word(2'd3, 8'hff, 8'hff, 8'hff);
    for (int i = 0; i < 17; i++) add_word(dprt_pkg::REQ_ADV, 8'(100 + i), 8'd9, 8'(i));
    add_word(dprt_pkg::REQ_TICK, 8'd0, 8'd0, 8'd0);
    drain_all();

    write_reg(dprt_pkg::CFG_OWN, 8'd255);
    write_reg(dprt_pkg::CFG_BCAST, 8'd0);
    send_idle_pct = 0;
    random_phase(40, 8'd255);
    while (pending_words.size() > 0) @(posedge clk);
    // hold off until every expected word is back
    send_hold = 1'b1;
    drain_all();
    send_hold = 1'b0;
    random_phase(40, 8'd255);
    drain_all();

    write_reg(dprt_pkg::CFG_OWN, 8'd7);
    write_reg(dprt_pkg::CFG_BCAST, 8'd255);
    send_idle_pct = 68;
    random_phase(80, 8'd7);
    drain_all();

    write_reg(dprt_pkg::CFG_OWN, 8'd0);
    write_reg(dprt_pkg::CFG_BCAST, 8'd3);
    send_idle_pct = 32;
    random_phase(80, 8'd0);
    drain_all();

    write_reg(dprt_pkg::CFG_OWN, 8'd200);
    send_idle_pct = 0;
    random_phase(80, 8'd200);
    drain_all();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
